>>> rtl/pfla_pkg.sv
// pfla_pkg: constants, codes and shared types of the power-of-two page allocator
// used by the interfaces, the register port, the allocator core and the top level
package pfla_pkg;

    localparam int PAGE_BITS    = 12;
    localparam int MIN_ORDER    = 12;
    localparam int ORDER_LIMIT  = 25;
    localparam int REGION_PAGES = 4096;

    localparam int ADDR_W     = 48;
    localparam int LEN_W      = 25;
    localparam int SIZE_W     = 32;
    localparam int PAGE_W     = $clog2(REGION_PAGES);
    localparam int NUM_ORDERS = ORDER_LIMIT - MIN_ORDER;
    localparam int IDX_W      = $clog2(NUM_ORDERS);
    localparam int ORD_W      = $clog2(ORDER_LIMIT + 1);

    localparam int APB_DW    = 64;
    localparam int APB_AW    = 4;
    localparam int REG_SHIFT = 3;

    localparam logic REG_BASE   = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_MEM    = 2'd2,
        ST_BAD_ADDR  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ORDER,
        S_CHECK,
        S_FPUSH,
        S_POP_RD,
        S_POP_WB,
        S_SPLIT,
        S_BUMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
    } t_link;

    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        t_link             wdata;
        logic              re;
        logic [PAGE_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [ADDR_W-1:0] region_base;
        logic [LEN_W-1:0]  region_length;
    } t_cfg;

endpackage

>>> rtl/pfla_req_if.sv
// pfla_req_if: request channel (valid/ready) carrying one allocate or free word
// depends on pfla_pkg
interface pfla_req_if import pfla_pkg::*; ();
    logic              valid;
    logic              ready;
    t_func             func;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] free_addr;

    modport source (output valid, output func, output req_size, output free_addr,
                    input ready);
    modport sink (input valid, input func, input req_size, input free_addr,
                  output ready);
endinterface

>>> rtl/pfla_rsp_if.sv
// pfla_rsp_if: response channel (valid/ready) carrying address and status
// depends on pfla_pkg
interface pfla_rsp_if import pfla_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] block_addr;
    t_status           status;

    modport source (output valid, output block_addr, output status, input ready);
    modport sink (input valid, input block_addr, input status, output ready);
endinterface

>>> rtl/pfla_ram.sv
// pfla_ram: generic single-write, single-read synchronous ram, registered read
// no package dependencies
module pfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/pfla_apb.sv
// pfla_apb: apb register port holding region base and region length
// depends on pfla_pkg
module pfla_apb import pfla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);
    logic [ADDR_W-1:0] r_base, n_base;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_base = r_base;
        n_len  = r_len;
        if (w_wr) begin
            case (paddr[REG_SHIFT])
                REG_BASE:   n_base = pwdata[ADDR_W-1:0];
                REG_LENGTH: n_len  = pwdata[LEN_W-1:0];
                default:    n_base = r_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_len  <= '0;
        end else begin
            r_base <= n_base;
            r_len  <= n_len;
        end
    end

    always_comb begin
        case (paddr[REG_SHIFT])
            REG_BASE:   prdata = APB_DW'(r_base);
            REG_LENGTH: prdata = APB_DW'(r_len);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.region_base   = r_base;
    assign o_cfg.region_length = r_len;
endmodule

>>> rtl/pfla_core.sv
// pfla_core: allocator sequencer, list heads, break offset and response register
// depends on pfla_pkg, pfla_req_if, pfla_rsp_if; drives the link ram
module pfla_core import pfla_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    pfla_req_if.sink    i_req,
    pfla_rsp_if.source  o_rsp,
    output t_ram_req    o_ram,
    input  t_link       i_ram_rdata
);
    t_state r_state, n_state;

    t_func             r_func;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_faddr;

    logic [ORD_W-1:0]      r_ord, n_ord;
    logic [ADDR_W-1:0]     r_off, n_off;
    logic                  r_below, n_below;
    logic [NUM_ORDERS-1:0] r_hv, n_hv;
    logic [PAGE_W-1:0]     r_head [NUM_ORDERS];
    logic [PAGE_W-1:0]     n_head [NUM_ORDERS];
    logic [ORD_W-1:0]      r_top, n_top;
    logic [LEN_W-1:0]      r_brk, n_brk;
    logic [IDX_W-1:0]      r_sel, n_sel;
    logic [PAGE_W-1:0]     r_page, n_page;
    logic [ORD_W-1:0]      r_j, n_j;
    logic [ADDR_W-1:0]     r_res_addr, n_res_addr;
    t_status               r_res_status, n_res_status;
    logic [ADDR_W-1:0]     r_out_addr;
    t_status               r_out_status;
    logic                  r_out_valid, n_out_valid;

    logic                  w_in_acc;
    logic                  w_out_load;
    logic [ORD_W-1:0]      w_order;
    logic                  w_found;
    logic [IDX_W-1:0]      w_fidx;
    logic [ORD_W-1:0]      w_newtop;
    logic [IDX_W-1:0]      w_hidx;
    logic [PAGE_W-1:0]     w_head;
    logic                  w_hv;
    logic [PAGE_W:0]       w_half;
    logic                  w_half_ok;
    logic                  w_split_go;
    logic                  w_bad;
    logic [LEN_W:0]        w_nb;
    logic                  w_nb_ok;
    logic                  w_push;
    logic [PAGE_W-1:0]     w_push_page;
    logic [ORD_W-1:0]      w_push_ord;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func  <= i_req.func;
            r_size  <= i_req.req_size;
            r_faddr <= i_req.free_addr;
        end
    end

    // rounded order of the request size
    always_comb begin
        w_order = ORD_W'(ORDER_LIMIT);
        for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
            if ({1'b0, r_size} <= ((SIZE_W + 1)'(1) << (PAGE_BITS + k))) begin
                w_order = ORD_W'(MIN_ORDER + k);
            end
        end
    end

    // smallest non-empty list between the request order and the top order
    always_comb begin
        w_found = 1'b0;
        w_fidx  = '0;
        for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
            if (r_hv[k] && (ORD_W'(MIN_ORDER + k) >= r_ord)
                    && (ORD_W'(MIN_ORDER + k) <= r_top)) begin
                w_found = 1'b1;
                w_fidx  = IDX_W'(k);
            end
        end
    end

    // highest non-empty list below the popped one
    always_comb begin
        w_newtop = '0;
        for (int k = 0; k < NUM_ORDERS; k++) begin
            if (r_hv[k] && (IDX_W'(k) < r_sel)) begin
                w_newtop = ORD_W'(MIN_ORDER + k);
            end
        end
    end

    always_comb begin
        case (r_state)
            S_FPUSH: w_hidx = IDX_W'(r_ord - ORD_W'(MIN_ORDER));
            S_SPLIT: w_hidx = IDX_W'(r_j - ORD_W'(MIN_ORDER + 1));
            default: w_hidx = r_sel;
        endcase
    end

    assign w_head     = r_head[w_hidx];
    assign w_hv       = r_hv[w_hidx];
    assign w_split_go = (r_j > r_ord);
    assign w_half     = {1'b0, r_page} + ((PAGE_W + 1)'(1) << w_hidx);
    assign w_half_ok  = (w_half < (PAGE_W + 1)'(REGION_PAGES));
    assign w_bad      = r_below || (r_off >= ADDR_W'(i_cfg.region_length))
                        || ((r_off >> PAGE_BITS) >= ADDR_W'(REGION_PAGES));
    assign w_nb       = {1'b0, r_brk} + ((LEN_W + 1)'(1) << r_ord);
    assign w_nb_ok    = (w_nb <= {1'b0, i_cfg.region_length});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_ORDER;
                end
            end
            S_ORDER: n_state = S_CHECK;
            S_CHECK: begin
                if (r_ord >= ORD_W'(ORDER_LIMIT)) begin
                    n_state = S_DONE;
                end else if (r_func == FN_FREE) begin
                    n_state = w_bad ? S_DONE : S_FPUSH;
                end else begin
                    n_state = w_found ? S_POP_RD : S_BUMP;
                end
            end
            S_FPUSH:  n_state = S_DONE;
            S_POP_RD: n_state = S_POP_WB;
            S_POP_WB: n_state = S_SPLIT;
            S_SPLIT: begin
                if (!w_split_go) begin
                    n_state = S_DONE;
                end
            end
            S_BUMP: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_ord        = r_ord;
        n_off        = r_off;
        n_below      = r_below;
        n_hv         = r_hv;
        n_head       = r_head;
        n_top        = r_top;
        n_brk        = r_brk;
        n_sel        = r_sel;
        n_page       = r_page;
        n_j          = r_j;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        w_out_load   = 1'b0;
        w_push       = 1'b0;
        w_push_page  = '0;
        w_push_ord   = '0;
        o_ram        = '0;
        case (r_state)
            S_ORDER: begin
                n_ord              = w_order;
                {n_below, n_off}   = {1'b0, r_faddr} - {1'b0, i_cfg.region_base};
            end
            S_CHECK: begin
                n_res_addr   = '0;
                n_res_status = ST_OK;
                n_sel        = w_fidx;
                if (r_ord >= ORD_W'(ORDER_LIMIT)) begin
                    n_res_status = ST_TOO_LARGE;
                end else if (r_func == FN_FREE && w_bad) begin
                    n_res_status = ST_BAD_ADDR;
                end
            end
            S_FPUSH: begin
                w_push      = 1'b1;
                w_push_page = r_off[PAGE_BITS +: PAGE_W];
                w_push_ord  = r_ord;
            end
            S_POP_RD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = w_head;
                n_page      = w_head;
            end
            S_POP_WB: begin
                n_head[r_sel] = i_ram_rdata.page;
                n_hv[r_sel]   = i_ram_rdata.valid;
                if (!i_ram_rdata.valid && (r_top == ORD_W'(MIN_ORDER) + ORD_W'(r_sel))) begin
                    n_top = w_newtop;
                end
                n_j        = ORD_W'(MIN_ORDER) + ORD_W'(r_sel);
                n_res_addr = i_cfg.region_base + (ADDR_W'(r_page) << PAGE_BITS);
            end
            S_SPLIT: begin
                if (w_split_go) begin
                    n_j = r_j - ORD_W'(1);
                    if (w_half_ok) begin
                        w_push      = 1'b1;
                        w_push_page = w_half[PAGE_W-1:0];
                        w_push_ord  = r_j - ORD_W'(1);
                    end
                end
            end
            S_BUMP: begin
                if (w_nb_ok) begin
                    n_res_addr = i_cfg.region_base + ADDR_W'(r_brk);
                    n_brk      = w_nb[LEN_W-1:0];
                end else begin
                    n_res_status = ST_NO_MEM;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: n_ord = r_ord;
        endcase
        // push onto the head of a list, old head goes into the link memory
        if (w_push) begin
            o_ram.we           = 1'b1;
            o_ram.waddr        = w_push_page;
            o_ram.wdata.valid  = w_hv;
            o_ram.wdata.page   = w_head;
            n_head[w_hidx]     = w_push_page;
            n_hv[w_hidx]       = 1'b1;
            if (r_top < w_push_ord) begin
                n_top = w_push_ord;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hv        <= '0;
            r_top       <= '0;
            r_brk       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hv        <= n_hv;
            r_top       <= n_top;
            r_brk       <= n_brk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ord        <= n_ord;
        r_off        <= n_off;
        r_below      <= n_below;
        r_head       <= n_head;
        r_sel        <= n_sel;
        r_page       <= n_page;
        r_j          <= n_j;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        if (w_out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.block_addr = r_out_addr;
    assign o_rsp.status     = r_out_status;
endmodule

>>> rtl/pow2_free_list_page_allocator_unit.sv
// pow2_free_list_page_allocator_unit: top level of the power-of-two page allocator
// depends on pfla_pkg, pfla_req_if, pfla_rsp_if, pfla_ram, pfla_apb, pfla_core
//
// usage
//   i_req carries one word per request: func (allocate or free), req_size and,
//   for a free, free_addr. o_rsp returns one word per request: block_addr and
//   status. region_base (byte 0) and region_length (byte 8) are written over
//   the apb port while no request is in flight.
//   one request is worked at a time. a rejected request ends after the order and
//   check steps; a free pushes its page onto a list, a bump allocation moves the
//   break offset, and a list allocation reads the head, takes its link as new head
//   and splits the block down to the request order, one split half (0 to 12 in
//   all) per cycle through the single write port of the link memory. the next
//   request is taken in the cycle after the result enters the output register.
//   the output register holds a result while o_rsp.ready is low; the next
//   request is still accepted and worked, and waits for the register to free.
//   reset empties all lists, zeroes the break offset and both registers; the
//   link memory needs no clearing since only pushed entries are ever read.
module pow2_free_list_page_allocator_unit import pfla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pfla_req_if.sink          i_req,
    pfla_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    t_cfg                    w_cfg;
    t_ram_req                w_ram;
    logic [$bits(t_link)-1:0] w_rdata;

    pfla_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pfla_ram #(
        .WIDTH ($bits(t_link)),
        .DEPTH (REGION_PAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    pfla_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_ram       (w_ram),
        .i_ram_rdata (t_link'(w_rdata))
    );
endmodule
